/* hdl/mtfg_pkg.sv */
// Shared types, constants and helpers for the meteor trail frame generator.
`timescale 1ns / 1ps

package mtfg_pkg;

  localparam int unsigned StripLengthDefault = 64;

  localparam int unsigned PixW     = 6;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned FrameW   = 9;
  localparam int unsigned LenW     = 8;
  localparam int unsigned MaskW    = 64;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegColor  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegLength = 3'd1;
  localparam logic [CfgAddrW-1:0] RegDecay  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegRandom = 3'd3;
  localparam logic [CfgAddrW-1:0] RegExtra  = 3'd4;

  // register reset values
  localparam logic [ColorW-1:0] ColorReset  = 24'hFFFFFF;
  localparam logic [LenW-1:0]   LengthReset = 8'd10;
  localparam logic [ChanW-1:0]  DecayReset  = 8'd64;
  localparam logic              RandomReset = 1'b1;
  localparam logic [LenW-1:0]   ExtraReset  = 8'd50;

  typedef struct packed {
    logic             restart;
    logic [MaskW-1:0] decay_mask;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0]  pixel_index;
    logic [ChanW-1:0] red_level;
    logic [ChanW-1:0] green_level;
    logic [ChanW-1:0] blue_level;
    logic             frame_end;
    logic             run_done;
  } out_item_t;

  typedef struct packed {
    logic start;  // latch the frame tick, read pixel zero
    logic step;   // finish current pixel, move it to the output
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;   // output register empty or being taken
    logic last_pixel;  // current pixel is the last of the strip
  } ctrl_status_t;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } ctrl_state_e;

  // channel * keep >> 8
  function automatic logic [ChanW-1:0] fade_channel(input logic [ChanW-1:0] chan,
                                                    input logic [ChanW-1:0] keep);
    logic [2*ChanW-1:0] prod;
    prod = chan * keep;
    return prod[2*ChanW-1:ChanW];
  endfunction

endpackage

/* hdl/mtfg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mtfg_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mtfg_ctrl.sv */
// Frame sequencer: takes a frame tick and steps the datapath through the strip.
`timescale 1ns / 1ps

module mtfg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mtfg_pkg::ctrl_status_t status_i,
  output mtfg_pkg::ctrl_cmd_t    cmd_o
);

  mtfg_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      mtfg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = mtfg_pkg::StRun;
        end
      end
      mtfg_pkg::StRun: begin
        if (status_i.slot_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_pixel) begin
            state_d = mtfg_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = mtfg_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtfg_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/mtfg_datapath.sv */
// Pixel datapath: config registers, pixel store, fade and paint, output register.
`timescale 1ns / 1ps

module mtfg_datapath #(
  parameter int unsigned STRIP_LENGTH = mtfg_pkg::StripLengthDefault,
  parameter int unsigned ADDR_W       = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mtfg_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [mtfg_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  mtfg_pkg::in_item_t                in_data_i,
  input  mtfg_pkg::ctrl_cmd_t               cmd_i,
  output mtfg_pkg::ctrl_status_t            status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mtfg_pkg::out_item_t               out_data_o
);

  localparam int unsigned PixW   = mtfg_pkg::PixW;
  localparam int unsigned ChanW  = mtfg_pkg::ChanW;
  localparam int unsigned ColorW = mtfg_pkg::ColorW;
  localparam int unsigned FrameW = mtfg_pkg::FrameW;
  localparam int unsigned LenW   = mtfg_pkg::LenW;

  // configuration
  logic [ColorW-1:0] color_q;
  logic [LenW-1:0]   length_q;
  logic [ChanW-1:0]  decay_q;
  logic              random_q;
  logic [LenW-1:0]   extra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q  <= mtfg_pkg::ColorReset;
      length_q <= mtfg_pkg::LengthReset;
      decay_q  <= mtfg_pkg::DecayReset;
      random_q <= mtfg_pkg::RandomReset;
      extra_q  <= mtfg_pkg::ExtraReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        mtfg_pkg::RegColor:  color_q  <= cfg_wdata_i[ColorW-1:0];
        mtfg_pkg::RegLength: length_q <= cfg_wdata_i[LenW-1:0];
        mtfg_pkg::RegDecay:  decay_q  <= cfg_wdata_i[ChanW-1:0];
        mtfg_pkg::RegRandom: random_q <= cfg_wdata_i[0];
        mtfg_pkg::RegExtra:  extra_q  <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // per-frame state
  logic [mtfg_pkg::MaskW-1:0] mask_q;
  logic [FrameW-1:0]          frame_q;
  logic [FrameW-1:0]          frame_idx_q;
  logic [PixW-1:0]            pix_q;
  logic [PixW-1:0]            pix_next;
  logic                       last_pixel;
  logic [FrameW-1:0]          last_frame;
  logic                       run_done;

  assign pix_next   = pix_q + PixW'(1);
  assign last_pixel = (pix_q == PixW'(STRIP_LENGTH - 1));
  assign last_frame = FrameW'(STRIP_LENGTH) + FrameW'(extra_q) - FrameW'(1);
  assign run_done   = (frame_q >= last_frame);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mask_q  <= in_data_i.decay_mask;
      frame_q <= in_data_i.restart ? '0 : frame_idx_q;
      pix_q   <= '0;
    end else if (cmd_i.step && !last_pixel) begin
      pix_q <= pix_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_idx_q <= '0;
    end else if (cmd_i.step && last_pixel) begin
      frame_idx_q <= run_done ? '0 : frame_q + FrameW'(1);
    end
  end

  // pixel store; frame zero reads as cleared
  logic [ColorW-1:0] rd_data;
  logic [ColorW-1:0] cur_pix;
  logic [ColorW-1:0] faded_pix;
  logic [ColorW-1:0] new_pix;
  logic [ChanW-1:0]  keep;
  logic              fade_en;
  logic              lit;
  logic [FrameW-1:0] pix_ext;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_en   = cmd_i.start || (cmd_i.step && !last_pixel);
  assign rd_addr = cmd_i.start ? '0 : pix_next[ADDR_W-1:0];

  mtfg_ram #(
    .WIDTH (ColorW),
    .DEPTH (STRIP_LENGTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.step),
    .waddr_i(pix_q[ADDR_W-1:0]),
    .wdata_i(new_pix),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign cur_pix = (frame_q == '0) ? '0 : rd_data;
  assign keep    = 8'hFF - decay_q;
  assign fade_en = !random_q || mask_q[pix_q];
  assign faded_pix = {mtfg_pkg::fade_channel(cur_pix[23:16], keep),
                      mtfg_pkg::fade_channel(cur_pix[15:8], keep),
                      mtfg_pkg::fade_channel(cur_pix[7:0], keep)};
  assign pix_ext = FrameW'(pix_q);
  assign lit     = (pix_ext <= frame_q) && ((frame_q - pix_ext) < FrameW'(length_q));
  assign new_pix = lit ? color_q : (fade_en ? faded_pix : cur_pix);

  // output register
  logic                out_valid_q;
  mtfg_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q.pixel_index <= pix_q;
      out_q.red_level   <= new_pix[23:16];
      out_q.green_level <= new_pix[15:8];
      out_q.blue_level  <= new_pix[7:0];
      out_q.frame_end   <= last_pixel;
      out_q.run_done    <= run_done;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_q;
  assign status_o.slot_free   = !out_valid_q || out_ready_i;
  assign status_o.last_pixel  = last_pixel;

endmodule

/* hdl/meteor_trail_frame_generator_core.sv */
// Top level of the meteor trail frame generator.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i): one transfer is one frame
//    tick carrying restart and the 64-bit decay mask.
//  - Output channel (out_valid_o/out_ready_i/out_data_o): STRIP_LENGTH pixel
//    transfers per frame, pixel zero first; frame_end marks the last pixel and
//    run_done is set on every pixel of a run's final frame.
//  - Config port (cfg_we_i/cfg_addr_i/cfg_wdata_i): single-cycle register
//    writes, only while no frame is in progress (user's rule, not enforced).
//  - First pixel: read at the tick transfer, then put in the output register.
//  - Throughput: one pixel per cycle from the pixel store read port while the
//    receiver takes pixels; the next tick is taken the cycle after the last
//    pixel moves into the output register.
//  - Receiver stall: the output register holds its pixel and the sequencer
//    pauses; no data is dropped.
//  - Reset: registers return to their defaults and the frame counter to
//    zero; the pixel store is not swept, since frame zero treats it as
//    cleared and rewrites every pixel.
module meteor_trail_frame_generator_core #(
  parameter int unsigned STRIP_LENGTH = mtfg_pkg::StripLengthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mtfg_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mtfg_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mtfg_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mtfg_pkg::out_item_t           out_data_o
);

  localparam int unsigned AddrW = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;

  mtfg_pkg::ctrl_cmd_t    cmd;
  mtfg_pkg::ctrl_status_t status;

  mtfg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mtfg_datapath #(
    .STRIP_LENGTH(STRIP_LENGTH),
    .ADDR_W      (AddrW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  a_busy_after_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("tick taken while a frame is in progress");

  a_frame_end_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |->
      (out_data_o.pixel_index == mtfg_pkg::PixW'(STRIP_LENGTH - 1)))
    else $error("frame_end on a pixel other than the last");

  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(cmd.step && status.last_pixel))
    else $error("sequencer went idle before the last pixel");

  a_step_needs_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (!out_valid_o || out_ready_i))
    else $error("pixel overwrote an untaken output");
`endif

endmodule
